// ----- rtl/sacache_pkg.sv -----
package sacache_pkg;

   localparam int NUM_SETS    = 16;
   localparam int NUM_WAYS    = 8;
   localparam int OFFSET_BITS = 3;

   localparam int ADDR_BITS   = 32;
   localparam int COUNT_BITS  = 32;
   localparam int OUT_TAG_BITS = 25;
   localparam int OUT_WAY_BITS = 3;

   localparam int INDEX_BITS  = $clog2(NUM_SETS);
   localparam int SET_BITS    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
   localparam int WAY_BITS    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - INDEX_BITS;

   localparam logic [ADDR_BITS:0] IDX_MASK = (33'd1 << INDEX_BITS) - 33'd1;
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic                    writeback;
      logic [OUT_WAY_BITS-1:0] way_used;
      logic [OUT_TAG_BITS-1:0] victim_tag;
      logic [COUNT_BITS-1:0]   read_count;
      logic [COUNT_BITS-1:0]   write_count;
      logic [COUNT_BITS-1:0]   read_hit_count;
      logic [COUNT_BITS-1:0]   write_hit_count;
      logic [COUNT_BITS-1:0]   read_miss_count;
      logic [COUNT_BITS-1:0]   write_miss_count;
      logic [COUNT_BITS-1:0]   writeback_count;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
      logic [WAY_BITS-1:0] rank;
   } line_type;

   typedef line_type [NUM_WAYS-1:0] row_type;

   // result of a full pass of the compare unit over one set
   typedef struct packed {
      logic                hit;
      logic                found;
      logic                last;
      logic [WAY_BITS-1:0] hit_way;
      logic [WAY_BITS-1:0] free_way;
      logic [WAY_BITS-1:0] lru_way;
   } scan_type;

   function automatic logic [SET_BITS-1:0] set_of(input logic [ADDR_BITS-1:0] addr);
      logic [ADDR_BITS-1:0] idx;
      idx = (addr >> OFFSET_BITS) & IDX_MASK[ADDR_BITS-1:0];
      // index field is below twice the set count
      if (idx >= ADDR_BITS'(NUM_SETS)) begin
         idx = idx - ADDR_BITS'(NUM_SETS);
      end
      return SET_BITS'(idx);
   endfunction

   function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] addr);
      return TAG_BITS'(addr >> (OFFSET_BITS + INDEX_BITS));
   endfunction

   // contents of a set that has never been written
   function automatic row_type reset_row();
      row_type r;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r[w].valid = 1'b0;
         r[w].dirty = 1'b0;
         r[w].tag   = '0;
         r[w].rank  = WAY_BITS'(w);
      end
      return r;
   endfunction

endpackage

// ----- rtl/sacache_mem.sv -----
module sacache_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [sacache_pkg::SET_BITS-1:0] rd_set,
   input  logic                          wr_en,
   input  logic [sacache_pkg::SET_BITS-1:0] wr_set,
   input  sacache_pkg::row_type          wr_row,
   output sacache_pkg::row_type          rd_row
);
   import sacache_pkg::*;

   row_type row_mem [NUM_SETS];
   logic [NUM_SETS-1:0] written_ff;
   logic [NUM_SETS-1:0] written_in;
   row_type rd_data_ff;
   logic    rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_set] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_set];
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_set] = 1'b1;
      end
   end

   // per-set written flags stand in for clearing the array at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_set];
         end
      end
   end

   assign rd_row = rd_written_ff ? rd_data_ff : reset_row();

endmodule

// ----- rtl/sacache_scan.sv -----
module sacache_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             step,
   input  sacache_pkg::row_type             row,
   input  logic [sacache_pkg::TAG_BITS-1:0] tag,
   output sacache_pkg::scan_type            result
);
   import sacache_pkg::*;

   logic [WAY_BITS-1:0] way_cnt_ff, way_cnt_in;
   logic                hit_ff, hit_in;
   logic                found_ff, found_in;
   logic [WAY_BITS-1:0] hit_way_ff, hit_way_in;
   logic [WAY_BITS-1:0] free_way_ff, free_way_in;
   logic [WAY_BITS-1:0] lru_way_ff, lru_way_in;
   line_type            cur;
   logic                last;

   assign cur  = row[way_cnt_ff];
   assign last = (way_cnt_ff == WAY_BITS'(NUM_WAYS - 1));

   // one way is compared each step
   always_comb begin
      way_cnt_in  = way_cnt_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      hit_way_in  = hit_way_ff;
      free_way_in = free_way_ff;
      lru_way_in  = lru_way_ff;
      if (start) begin
         way_cnt_in = '0;
         hit_in     = 1'b0;
         found_in   = 1'b0;
      end else if (step) begin
         if (cur.valid && cur.tag == tag && !hit_ff) begin
            hit_in     = 1'b1;
            hit_way_in = way_cnt_ff;
         end
         if (!cur.valid && !found_ff) begin
            found_in    = 1'b1;
            free_way_in = way_cnt_ff;
         end
         if (cur.rank == WAY_BITS'(NUM_WAYS - 1)) begin
            lru_way_in = way_cnt_ff;
         end
         way_cnt_in = last ? '0 : way_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         way_cnt_ff <= '0;
         hit_ff     <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         way_cnt_ff <= way_cnt_in;
         hit_ff     <= hit_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff  <= hit_way_in;
      free_way_ff <= free_way_in;
      lru_way_ff  <= lru_way_in;
   end

   assign result.hit      = hit_ff;
   assign result.found    = found_ff;
   assign result.last     = last;
   assign result.hit_way  = hit_way_ff;
   assign result.free_way = free_way_ff;
   assign result.lru_way  = lru_way_ff;

endmodule

// ----- rtl/set_assoc_cache_lru_writeback_core.sv -----
// channel   ports                               direction  payload
// request   req_valid, req_stall, req_payload   in         action, address
// response  rsp_valid, rsp_stall, rsp_payload   out        hit, way, victim, counters
//
// an access reads the set row, passes one way per step through the single tag
// compare unit, then writes the row back.
// reset is synchronous; no clearing pass, unwritten sets read as empty.
// one response register: the next request is taken while a response waits,
// and the row write is held while the previous response is still stalled.
module set_assoc_cache_lru_writeback_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sacache_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sacache_pkg::rsp_type rsp_payload
);
   import sacache_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [COUNT_BITS-1:0] reads_ff, writes_ff, rd_hits_ff, wr_hits_ff;
   logic [COUNT_BITS-1:0] rd_misses_ff, wr_misses_ff, wbs_ff;
   logic [COUNT_BITS-1:0] reads_in, writes_in, rd_hits_in, wr_hits_in;
   logic [COUNT_BITS-1:0] rd_misses_in, wr_misses_in, wbs_in;

   logic                req_take;
   logic                commit;
   logic [SET_BITS-1:0] cur_set;
   logic [TAG_BITS-1:0] cur_tag;
   row_type             row;
   row_type             new_row;
   scan_type            scan;
   logic [WAY_BITS-1:0] sel_way;
   line_type            old_line;
   logic                wb;
   logic                is_write;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign cur_set   = set_of(req_ff.address);
   assign cur_tag   = tag_of(req_ff.address);
   assign is_write  = (req_ff.action == ACT_WRITE);
   assign commit    = (state_ff == S_UPDATE) && !(rsp_valid_ff && rsp_stall);

   sacache_mem u_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_take),
      .rd_set (set_of(req_payload.address)),
      .wr_en  (commit),
      .wr_set (cur_set),
      .wr_row (new_row),
      .rd_row (row)
   );

   sacache_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (req_take),
      .step   (state_ff == S_SCAN),
      .row    (row),
      .tag    (cur_tag),
      .result (scan)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan.last) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hit way, else lowest free way, else least recent way
   always_comb begin
      if (scan.hit) begin
         sel_way = scan.hit_way;
      end else if (scan.found) begin
         sel_way = scan.free_way;
      end else begin
         sel_way = scan.lru_way;
      end
   end

   assign old_line = row[sel_way];
   assign wb       = !scan.hit && !scan.found && old_line.dirty;

   always_comb begin
      new_row = row;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (row[w].rank < old_line.rank) begin
            new_row[w].rank = row[w].rank + 1'b1;
         end
      end
      new_row[sel_way].rank = '0;
      if (scan.hit) begin
         if (is_write) begin
            new_row[sel_way].dirty = 1'b1;
         end
      end else begin
         new_row[sel_way].valid = 1'b1;
         new_row[sel_way].tag   = cur_tag;
         new_row[sel_way].dirty = is_write;
      end
   end

   always_comb begin
      reads_in     = reads_ff;
      writes_in    = writes_ff;
      rd_hits_in   = rd_hits_ff;
      wr_hits_in   = wr_hits_ff;
      rd_misses_in = rd_misses_ff;
      wr_misses_in = wr_misses_ff;
      wbs_in       = wbs_ff;
      if (commit) begin
         if (is_write) begin
            writes_in = writes_ff + 1'b1;
            if (scan.hit) begin
               wr_hits_in = wr_hits_ff + 1'b1;
            end else begin
               wr_misses_in = wr_misses_ff + 1'b1;
            end
         end else begin
            reads_in = reads_ff + 1'b1;
            if (scan.hit) begin
               rd_hits_in = rd_hits_ff + 1'b1;
            end else begin
               rd_misses_in = rd_misses_ff + 1'b1;
            end
         end
         if (wb) begin
            wbs_in = wbs_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in                  = rsp_ff;
      rsp_valid_in            = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.hit              = scan.hit;
         rsp_in.writeback        = wb;
         rsp_in.way_used         = OUT_WAY_BITS'(sel_way);
         rsp_in.victim_tag       = wb ? OUT_TAG_BITS'(old_line.tag) : '0;
         rsp_in.read_count       = reads_in;
         rsp_in.write_count      = writes_in;
         rsp_in.read_hit_count   = rd_hits_in;
         rsp_in.write_hit_count  = wr_hits_in;
         rsp_in.read_miss_count  = rd_misses_in;
         rsp_in.write_miss_count = wr_misses_in;
         rsp_in.writeback_count  = wbs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         rd_hits_ff   <= '0;
         wr_hits_ff   <= '0;
         rd_misses_ff <= '0;
         wr_misses_ff <= '0;
         wbs_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         rd_hits_ff   <= rd_hits_in;
         wr_hits_ff   <= wr_hits_in;
         rd_misses_ff <= rd_misses_in;
         wr_misses_ff <= wr_misses_in;
         wbs_ff       <= wbs_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_take) begin
         req_ff <= req_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_SCAN)
      else $error("accepted transaction did not start the way scan");

   a_hit_no_writeback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> !rsp_payload.writeback)
      else $error("write-back reported on a hit");

   a_read_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.read_count ==
         rsp_payload.read_hit_count + rsp_payload.read_miss_count)
      else $error("read counters out of step");

   a_write_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.write_count ==
         rsp_payload.write_hit_count + rsp_payload.write_miss_count)
      else $error("write counters out of step");

endmodule
